FILE: hdl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int MAX_SIZE_LOG2_DEF = 10;
  localparam int SIZE_LOG2_RESET   = 10;

  localparam int CFG_W          = 4;
  localparam int REQ_W          = 2;
  localparam int WORD_W         = 32;
  localparam int SLOT_INDEX_W   = 10;
  localparam int USED_COUNT_W   = 11;
  localparam int IN_TDATA_W     = 96;
  localparam int OUT_TDATA_W    = 56;
  localparam int OUT_TUSER_W    = 2;

  localparam logic [REQ_W-1:0] REQ_GET_OR_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND_INDEX = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND_VALUE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_MATCH_PAIR = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] key_hash;
    logic [WORD_W-1:0] key_ref;
    logic [WORD_W-1:0] value_ref;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic                    inserted;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [WORD_W-1:0]       value_out;
    logic [USED_COUNT_W-1:0] used_count;
  } result_t;

  // one table row; zero hash marks an empty row
  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic in_ready;
    logic clearing;
    logic res_valid;
  } ctrl_status_t;

endpackage

FILE: hdl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing (hash, key, value) table with linear probing.
// ----------------------------------------------------------------------------
//  port group | dir | beat contents
//  s_axis_*   | in  | tuser: req_type; tdata: key_hash, key_ref, value_ref
//  m_axis_*   | out | tuser: found, inserted; tdata: slot_index, value_out,
//             |     |        used_count
//  cfg_*      | in  | table_size_log2, write-only
//
// A request reads P slots (at most 2^size - 1), one slot memory read per
// cycle in the probe sequencer.
// After reset a clear sweep zeroes the slot hashes; s_axis_tready stays
// low meanwhile.
// A result waits in the output register; a new request is taken meanwhile,
// and the sequencer holds its next result until that register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int MAX_SIZE_LOG2 = lpht_pkg::MAX_SIZE_LOG2_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_hash [31:0], key_ref [63:32], value_ref [95:64]
  input  logic [lpht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type [1:0]
  input  logic [lpht_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // slot_index [9:0], value_out [41:10], used_count [52:42], zero [55:53]
  output logic [lpht_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // found [0], inserted [1]
  output logic [lpht_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  input  logic                               cfg_wen,
  input  logic [lpht_pkg::CFG_W-1:0]         cfg_wdata
);
  import lpht_pkg::*;

  localparam int SIZE_W     = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int SIZE_RESET = (SIZE_LOG2_RESET > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2
                                                               : SIZE_LOG2_RESET;

  logic [SIZE_W-1:0]        size_log2;
  req_t                     in_req;
  result_t                  ctrl_res, out_res;
  ctrl_status_t             status;
  logic                     res_take;
  logic                     ram_we, ram_re;
  logic [MAX_SIZE_LOG2-1:0] ram_waddr, ram_raddr;
  slot_t                    ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_W'(SIZE_RESET);
    end else if (cfg_wen) begin
      if (32'(cfg_wdata) > MAX_SIZE_LOG2) begin
        size_log2 <= SIZE_W'(MAX_SIZE_LOG2);
      end else begin
        size_log2 <= SIZE_W'(cfg_wdata);
      end
    end
  end

  assign in_req.req_type  = s_axis_tuser;
  assign in_req.key_hash  = s_axis_tdata[31:0];
  assign in_req.key_ref   = s_axis_tdata[63:32];
  assign in_req.value_ref = s_axis_tdata[95:64];

  assign res_take = !m_axis_tvalid || m_axis_tready;

  lpht_probe_ctrl #(
    .ADDR_W (MAX_SIZE_LOG2),
    .SIZE_W (SIZE_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .size_log2 (size_log2),
    .in_valid  (s_axis_tvalid),
    .in_req    (in_req),
    .res_take  (res_take),
    .res       (ctrl_res),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lpht_slot_ram #(
    .ADDR_W (MAX_SIZE_LOG2)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = status.in_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= status.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid && res_take) begin
      out_res <= ctrl_res;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_res.used_count, out_res.value_out,
                                      out_res.slot_index});
  assign m_axis_tuser = {out_res.inserted, out_res.found};

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !s_axis_tready)
    else $error("request taken during clear sweep");

  a_insert_is_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("inserted result without found");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[41:0] == '0)
    else $error("miss result carries index or value");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    status.res_valid && ctrl_res.inserted |-> ctrl_res.used_count != '0)
    else $error("insert left used count at zero");
`endif

endmodule

FILE: hdl/lpht_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_slot_ram
// Single-port-write, single-port-read slot memory, registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram #(
  parameter int ADDR_W = lpht_pkg::MAX_SIZE_LOG2_DEF
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  lpht_pkg::slot_t    wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output lpht_pkg::slot_t    rdata
);
  import lpht_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lpht_probe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_probe_ctrl
// Clear sweep after reset, then per-request probe sequencer: one slot read
// per cycle, compare, and write-back of a new slot on insert.
// ----------------------------------------------------------------------------
module lpht_probe_ctrl #(
  parameter int ADDR_W = lpht_pkg::MAX_SIZE_LOG2_DEF,
  parameter int SIZE_W = $clog2(ADDR_W + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SIZE_W-1:0]      size_log2,
  input  logic                   in_valid,
  input  lpht_pkg::req_t         in_req,
  input  logic                   res_take,
  output lpht_pkg::result_t      res,
  output lpht_pkg::ctrl_status_t status,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output lpht_pkg::slot_t        ram_wdata,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  lpht_pkg::slot_t        ram_rdata
);
  import lpht_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] mask_q;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W:0]   count, count_next;
  req_t              req_q;
  result_t           res_q;

  logic [ADDR_W-1:0] mask_in, start_in, idx_inc;
  logic              accept;
  logic              hash_eq, key_eq, val_eq, empty;
  logic              hit, ins, stop, last;
  logic              finish, load_res;
  result_t           res_new;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign mask_in  = ~({ADDR_W{1'b1}} << size_log2);
  assign start_in = in_req.key_hash[ADDR_W-1:0] & mask_in;
  assign idx_inc  = (idx + 1'b1) & mask_q;

  assign hash_eq = (ram_rdata.hash == req_q.key_hash);
  assign key_eq  = (ram_rdata.key == req_q.key_ref);
  assign val_eq  = (ram_rdata.value == req_q.value_ref);
  assign empty   = (ram_rdata.hash == '0);
  // no slots left after this one
  assign last    = ((n + 1'b1) == mask_q);

  always_comb begin
    hit  = 1'b0;
    ins  = 1'b0;
    stop = 1'b0;
    case (req_q.req_type)
      REQ_GET_OR_ADD: begin
        // a zero hash matches an empty slot here and never inserts
        if (hash_eq) begin
          hit = key_eq;
        end else begin
          ins = empty;
        end
      end
      REQ_MATCH_PAIR: begin
        stop = empty;
        hit  = !empty && hash_eq && key_eq && val_eq;
      end
      default: begin
        stop = empty;
        hit  = !empty && hash_eq && key_eq;
      end
    endcase
  end

  assign finish     = (state == ST_PROBE) && (hit || ins || stop || last);
  assign count_next = (state == ST_PROBE && ins) ? count + 1'b1 : count;

  always_comb begin
    res_new.found      = (hit || ins) && (state == ST_PROBE);
    res_new.inserted   = ins && (state == ST_PROBE);
    res_new.slot_index = res_new.found ? SLOT_INDEX_W'(idx) : '0;
    res_new.value_out  = !res_new.found ? '0 :
                         ins ? req_q.value_ref : ram_rdata.value;
    res_new.used_count = USED_COUNT_W'(count_next);
  end

  // empty table window: nothing to probe
  assign load_res = finish || (accept && mask_in == '0);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {ADDR_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_next   = start_in;
          state_next = (mask_in == '0) ? ST_HOLD : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (finish) begin
          state_next = ST_HOLD;
        end else begin
          idx_next = idx_inc;
        end
      end
      ST_HOLD: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      req_q  <= in_req;
      mask_q <= mask_in;
      n      <= '0;
    end else if (state == ST_PROBE) begin
      n <= n + 1'b1;
    end
    if (load_res) begin
      res_q <= res_new;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{hash: req_q.key_hash, key: req_q.key_ref, value: req_q.value_ref};
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_PROBE && ins) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = (accept && mask_in != '0) || (state == ST_PROBE && !finish);
  assign ram_raddr = (state == ST_IDLE) ? start_in : idx_inc;

  assign res              = res_q;
  assign status.in_ready  = (state == ST_IDLE);
  assign status.clearing  = (state == ST_CLEAR);
  assign status.res_valid = (state == ST_HOLD);

endmodule
